// ===== rtl/srle_pkg.sv =====
// Package with shared constants and types of the silence run-length encoder.
`default_nettype none

package srle_pkg;

  localparam int unsigned CNT_W  = 15;
  localparam int unsigned WORD_W = 16;

  // A run opens when this many zero pairs have been seen in a row.
  localparam logic [CNT_W-1:0] RUN_START = CNT_W'(3);
  // A run is cut at this count and counting starts over.
  localparam logic [CNT_W-1:0] RUN_LIMIT = CNT_W'(16'h7FFF - 16'd1);

  typedef enum logic {
    CMD_PAIR  = 1'b0,
    CMD_FLUSH = 1'b1
  } srle_cmd_t;

  // One output word pair.
  typedef struct packed {
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;
    logic              last_of_run;
  } srle_res_t;

  // The zero to two results that one input transaction produces.
  typedef struct packed {
    logic       valid;
    logic [1:0] num;
    srle_res_t  res0;
    srle_res_t  res1;
  } srle_batch_t;

endpackage

`default_nettype wire

// ===== rtl/srle_if.sv =====
// Stream interfaces for the input and result channels of the encoder.
`default_nettype none

interface srle_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, output command, output left_sample, output right_sample,
                  input ready);
  modport sink   (input valid, input command, input left_sample, input right_sample,
                  output ready);
endinterface

interface srle_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_word;
  logic signed [15:0] right_word;
  logic               last_of_run;

  modport source (output valid, output left_word, output right_word, output last_of_run,
                  input ready);
  modport sink   (input valid, input left_word, input right_word, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/srle_core.sv =====
// Input register, run state and result formation of the encoder.
`default_nettype none

module srle_core
  import srle_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_command,
  input  wire logic [15:0]  in_left,
  input  wire logic [15:0]  in_right,
  input  wire logic         q_space,
  output srle_batch_t       batch
);

  logic              in_vld_r, in_vld_nxt;
  logic              cmd_r;
  logic [15:0]       left_r, right_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              advance;
  logic              in_acc;
  logic              zero_pair;
  logic [CNT_W-1:0]  cnt_inc;
  srle_res_t         pair_res, cnt_res;
  srle_batch_t       b;

  assign advance  = in_vld_r && q_space;
  assign in_ready = !in_vld_r || advance;
  assign in_acc   = in_valid && in_ready;

  assign zero_pair = (left_r == 16'd0) && (right_r == 16'd0);
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_comb begin
    pair_res = '{left_word: left_r, right_word: right_r, last_of_run: 1'b1};
    cnt_res  = '{left_word: {1'b0, cnt_r}, right_word: {1'b0, cnt_r}, last_of_run: 1'b1};
    b        = '0;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    if (srle_cmd_t'(cmd_r) == CMD_FLUSH) begin
      if (run_r) begin
        b.res0 = cnt_res;
        b.num  = 2'd1;
      end
      cnt_nxt = '0;
      run_nxt = 1'b0;
    end else begin
      if (!run_r) begin
        b.res0 = pair_res;
        b.num  = 2'd1;
      end
      if (zero_pair) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == RUN_START) begin
          run_nxt = 1'b1;
        end else if (cnt_inc == RUN_LIMIT) begin
          // The run is cut; its count goes out behind whatever came first.
          cnt_res.left_word  = {1'b0, cnt_inc};
          cnt_res.right_word = {1'b0, cnt_inc};
          if (run_r) begin
            b.res0 = cnt_res;
          end else begin
            b.res1 = cnt_res;
          end
          b.num   = run_r ? 2'd1 : 2'd2;
          cnt_nxt = '0;
          run_nxt = 1'b0;
        end
      end else begin
        if (run_r) begin
          b.res0             = cnt_res;
          b.res0.last_of_run = 1'b0;
          b.res1             = pair_res;
          b.num              = 2'd2;
          run_nxt            = 1'b0;
        end
        cnt_nxt = '0;
      end
    end
    b.valid = advance;
  end

  assign batch = b;

  always_comb begin
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      cnt_r    <= '0;
      run_r    <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (advance) begin
        cnt_r <= cnt_nxt;
        run_r <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_command;
      left_r  <= in_left;
      right_r <= in_right;
    end
  end

  a_run_count_high: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (cnt_r >= RUN_START)) else $error("open run with count below start");
  a_idle_count_low: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (cnt_r < RUN_START)) else $error("count at start without open run");
  a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < RUN_LIMIT) else $error("run count reached limit and was kept");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r) |=> (cnt_r == '0 && !run_r)) else $error("flush left state");

endmodule

`default_nettype wire

// ===== rtl/srle_outq.sv =====
// Two-entry result register that drains the results of one transaction.
`default_nettype none

module srle_outq
  import srle_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire srle_batch_t  batch,
  output logic              q_space,
  output logic              out_valid,
  input  wire logic         out_ready,
  output srle_res_t         out_res
);

  logic [1:0] cnt_r, cnt_nxt;
  srle_res_t  slot0_r, slot1_r;
  logic       pop, push;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  // New results are taken only when the buffer is empty after this cycle.
  assign q_space   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign push      = batch.valid && (batch.num != 2'd0);
  assign out_res   = slot0_r;

  always_comb begin
    if (push) begin
      cnt_nxt = batch.num;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0_r <= batch.res0;
      slot1_r <= batch.res1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

  a_push_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop))) else $error("results overwritten");
  a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !slot0_r.last_of_run) else $error("first of two marked last");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (cnt_r == $past(batch.num))) else $error("result count lost");

endmodule

`default_nettype wire

// ===== rtl/silence_run_length_encoder.sv =====
// Data path: the first result of an input transaction passes through the input register and
//   then the result register before it is valid at the output.
// Throughput: one input transaction per cycle while each one yields at most one result and the
//   output is ready; a transaction that yields two results holds the input until the second of
//   them is taken, the two-entry result register being the limit.
// Reset: synchronous, active low; clears the run count, the run flag and all valid state.
`default_nettype none

module silence_run_length_encoder
  import srle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  srle_in_if.sink    in_ch,
  srle_out_if.source out_ch
);

  // Handshake between the core and the result register.
  srle_batch_t batch;
  logic        q_space;
  srle_res_t   out_res;
  logic        in_ready;
  logic        out_valid;

  // The core registers each input transaction, then forms its results from the registered
  // pair and the run state in one pass, updating the state when the results move on.
  srle_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_command (in_ch.command),
    .in_left    (in_ch.left_sample),
    .in_right   (in_ch.right_sample),
    .q_space    (q_space),
    .batch      (batch)
  );

  // The result register holds up to two results and hands them out one per transaction.
  srle_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .q_space   (q_space),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.left_word   = $signed(out_res.left_word);
  assign out_ch.right_word  = $signed(out_res.right_word);
  assign out_ch.last_of_run = out_res.last_of_run;

endmodule

`default_nettype wire
